// ===== hw/rtl/inertial_displacement_tracker_unit_assert.svh =====
// assertion macros for the displacement tracker checks
`ifndef INERTIAL_DISPLACEMENT_TRACKER_UNIT_ASSERT_SVH
`define INERTIAL_DISPLACEMENT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define IDT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idt check failed");

// next-cycle implication
`define IDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idt check failed");

`endif

// ===== hw/rtl/idt_pkg.sv =====
package idt_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic               trigger;
    logic [3:0]         trigger_count;
    logic               warmed_up;
  } result_t;

  typedef enum logic [2:0] {
    REG_SENS_GAIN     = 3'd0,
    REG_GRAVITY_ALPHA = 3'd1,
    REG_NOISE_TH      = 3'd2,
    REG_VEL_TH        = 3'd3,
    REG_DISP_TH       = 3'd4,
    REG_MAX_TRIG      = 3'd5,
    REG_WARMUP        = 3'd6,
    REG_RESET_INT     = 3'd7
  } cfg_reg_t;

  localparam logic [3:0]  STILL_LIMIT = 4'd10;
  localparam logic [3:0]  STILL_MAX   = 4'd15;
  localparam logic [9:0]  DIV_K       = 10'd1000;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi_lim;
    logic signed [65:0] lo_lim;
    hi_lim = 66'sh0_7FFF_FFFF;
    lo_lim = -66'sh0_8000_0000;
    if (x > hi_lim) return 32'sh7FFF_FFFF;
    if (x < lo_lim) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

// ===== hw/rtl/inertial_displacement_tracker_unit.sv =====
// one item at a time: a new item is taken only after the current one is written to the output
// per axis six bit-serial multiplies and two divides by 1000
// plus one multiply for the threshold square
// a finished result waits in the output register while the next item is taken
// rst (synchronous) restores register defaults and clears all tracking state
module inertial_displacement_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  idt_pkg::sample_t   sample,
  output logic               result_valid,
  input  logic               result_stall,
  output idt_pkg::result_t   result,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PRE   = 14'b00000000000010,
    S_MSCL  = 14'b00000000000100,
    S_MGOLD = 14'b00000000001000,
    S_MGNEW = 14'b00000000010000,
    S_ACC   = 14'b00000000100000,
    S_MVEL  = 14'b00000001000000,
    S_DVEL  = 14'b00000010000000,
    S_MPOS  = 14'b00000100000000,
    S_DPOS  = 14'b00001000000000,
    S_MSQ   = 14'b00010000000000,
    S_NEXT  = 14'b00100000000000,
    S_MTHR  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state;

  logic [15:0] sens_gain;
  logic [16:0] gravity_alpha;
  logic [19:0] noise_th;
  logic [19:0] vel_th;
  logic [30:0] disp_th;
  logic [3:0]  max_trig;
  logic [31:0] warmup_ms;
  logic [31:0] reset_int;

  logic signed [31:0] grav [3];
  logic signed [31:0] vel  [3];
  logic signed [31:0] pos  [3];
  logic [31:0] last_upd;
  logic [31:0] last_clr;
  logic [31:0] start_ms;
  logic        started;
  logic        warm;
  logic [3:0]  pulses;
  logic        exhausted;
  logic [3:0]  still_cnt;

  idt_pkg::sample_t   smp;
  logic [31:0]        dt;
  logic [1:0]         ax;
  logic signed [31:0] a_r;
  logic signed [49:0] t1;
  logic signed [31:0] gn_r;
  logic signed [31:0] accv;
  logic [63:0]        pmag;
  logic               psgn;
  logic [63:0]        dsq;
  logic               still_all;
  logic               pulse_r;
  logic               issued;

  logic               mul_start;
  logic               mul_done;
  logic [63:0]        mul_prod;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_sign;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_q;

  logic [16:0]        alpha_c;
  logic signed [15:0] raw;
  logic signed [64:0] sprod;
  logic signed [49:0] gsum;
  logic signed [31:0] gn;
  logic signed [31:0] accs;
  logic signed [31:0] accd;
  logic signed [65:0] sq;
  logic signed [31:0] vs;
  logic signed [31:0] vd;
  logic signed [31:0] ps;
  logic [31:0]        lclr_eff;
  logic [3:0]         sc_next;
  logic               zero_vel;
  logic               fin_go;
  logic               trig_ok;
  logic [3:0]         pulses_inc;

  assign alpha_c = (gravity_alpha > idt_pkg::ALPHA_ONE) ? idt_pkg::ALPHA_ONE : gravity_alpha;

  always_comb begin
    case (ax)
      2'd0:    raw = smp.accel_x;
      2'd1:    raw = smp.accel_y;
      default: raw = smp.accel_z;
    endcase
  end

  always_comb begin
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    mul_sign = 1'b0;
    unique case (state)
      S_MSCL: begin
        mul_a    = idt_pkg::mag32(32'(raw));
        mul_b    = {16'd0, sens_gain};
        mul_sign = raw[15];
      end
      S_MGOLD: begin
        mul_a    = idt_pkg::mag32(grav[ax]);
        mul_b    = {15'd0, idt_pkg::ALPHA_ONE - alpha_c};
        mul_sign = grav[ax][31];
      end
      S_MGNEW: begin
        mul_a    = idt_pkg::mag32(a_r);
        mul_b    = {15'd0, alpha_c};
        mul_sign = a_r[31];
      end
      S_MVEL: begin
        mul_a    = idt_pkg::mag32(accv);
        mul_b    = dt;
        mul_sign = accv[31];
      end
      S_MPOS: begin
        mul_a    = idt_pkg::mag32(vel[ax]);
        mul_b    = dt;
        mul_sign = vel[ax][31];
      end
      S_MSQ: begin
        mul_a = idt_pkg::mag32(pos[ax]);
        mul_b = idt_pkg::mag32(pos[ax]);
      end
      S_MTHR: begin
        mul_a = {1'b0, disp_th};
        mul_b = {1'b0, disp_th};
      end
      default: begin
        mul_a = 32'd0;
      end
    endcase
  end

  assign mul_start = !issued && (state == S_MSCL || state == S_MGOLD || state == S_MGNEW ||
                                 state == S_MVEL || state == S_MPOS || state == S_MSQ ||
                                 state == S_MTHR);
  assign div_start = !issued && (state == S_DVEL || state == S_DPOS);

  idt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  idt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pmag),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sprod = mul_sign ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
  assign gsum  = t1 + $signed(sprod[49:0]);
  assign gn    = idt_pkg::sat32(66'(gsum >>> 16));
  assign accs  = idt_pkg::sat32(66'(a_r) - 66'(gn_r));
  assign accd  = (idt_pkg::mag32(accs) < {12'd0, noise_th}) ? 32'sd0 : accs;
  assign sq    = psgn ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign vs    = idt_pkg::sat32(66'(vel[ax]) + sq);
  assign vd    = (idt_pkg::mag32(vs) < {12'd0, vel_th}) ? 32'sd0 : vs;
  assign ps    = idt_pkg::sat32(66'(pos[ax]) + sq);
  assign lclr_eff = started ? last_clr : smp.time_ms;

  assign sc_next  = still_all ? ((still_cnt < idt_pkg::STILL_MAX) ? still_cnt + 4'd1 : still_cnt)
                              : 4'd0;
  assign zero_vel = still_all && (sc_next > idt_pkg::STILL_LIMIT);
  assign fin_go   = !result_valid || !result_stall;
  assign trig_ok  = (dsq > mul_prod) && !exhausted && (pulses < max_trig);
  assign pulses_inc = pulses + 4'd1;

  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_gain     <= 16'd10048;
      gravity_alpha <= 17'd13107;
      noise_th      <= 20'd3277;
      vel_th        <= 20'd655;
      disp_th       <= 31'd32768;
      max_trig      <= 4'd5;
      warmup_ms     <= 32'd30000;
      reset_int     <= 32'd300000;
    end else if (cfg_we) begin
      unique case (idt_pkg::cfg_reg_t'(cfg_index))
        idt_pkg::REG_SENS_GAIN:     sens_gain     <= cfg_data[15:0];
        idt_pkg::REG_GRAVITY_ALPHA: gravity_alpha <= cfg_data[16:0];
        idt_pkg::REG_NOISE_TH:      noise_th      <= cfg_data[19:0];
        idt_pkg::REG_VEL_TH:        vel_th        <= cfg_data[19:0];
        idt_pkg::REG_DISP_TH:       disp_th       <= cfg_data[30:0];
        idt_pkg::REG_MAX_TRIG:      max_trig      <= cfg_data[3:0];
        idt_pkg::REG_WARMUP:        warmup_ms     <= cfg_data;
        idt_pkg::REG_RESET_INT:     reset_int     <= cfg_data;
        default:                    sens_gain     <= sens_gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      result_valid <= 1'b0;
      ax           <= 2'd0;
      last_upd     <= 32'd0;
      last_clr     <= 32'd0;
      start_ms     <= 32'd0;
      started      <= 1'b0;
      warm         <= 1'b0;
      pulses       <= 4'd0;
      exhausted    <= 1'b0;
      still_cnt    <= 4'd0;
      pulse_r      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        grav[i] <= 32'sd0;
        vel[i]  <= 32'sd0;
        pos[i]  <= 32'sd0;
      end
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (mul_start || div_start) issued <= 1'b1;
      if (mul_done || div_done) issued <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample_valid) state <= S_PRE;
        end
        S_PRE: begin
          if (!started) begin
            started  <= 1'b1;
            start_ms <= smp.time_ms;
            last_clr <= smp.time_ms;
          end
          if ((smp.time_ms - lclr_eff) >= reset_int) begin
            for (int i = 0; i < 3; i++) begin
              vel[i] <= 32'sd0;
              pos[i] <= 32'sd0;
            end
            last_clr <= smp.time_ms;
          end
          last_upd <= smp.time_ms;
          pulse_r  <= 1'b0;
          ax       <= 2'd0;
          state    <= S_MSCL;
        end
        S_MSCL: begin
          if (mul_done) state <= S_MGOLD;
        end
        S_MGOLD: begin
          if (mul_done) state <= S_MGNEW;
        end
        S_MGNEW: begin
          if (mul_done) begin
            grav[ax] <= gn;
            state    <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_MVEL;
        end
        S_MVEL: begin
          if (mul_done) state <= S_DVEL;
        end
        S_DVEL: begin
          if (div_done) begin
            vel[ax] <= vd;
            state   <= S_MPOS;
          end
        end
        S_MPOS: begin
          if (mul_done) state <= S_DPOS;
        end
        S_DPOS: begin
          if (div_done) begin
            pos[ax] <= ps;
            state   <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (mul_done) state <= S_NEXT;
        end
        S_NEXT: begin
          if (ax == 2'd2) begin
            state <= S_MTHR;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MSCL;
          end
        end
        S_MTHR: begin
          if (mul_done) begin
            if (trig_ok) begin
              if (!warm) begin
                if ((smp.time_ms - start_ms) >= warmup_ms) warm <= 1'b1;
              end else begin
                pulse_r <= 1'b1;
                pulses  <= pulses_inc;
                if (pulses_inc >= max_trig) exhausted <= 1'b1;
              end
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            still_cnt    <= sc_next;
            if (zero_vel) begin
              for (int i = 0; i < 3; i++) vel[i] <= 32'sd0;
            end
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload and per-item working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample_valid) smp <= sample;
    if (state == S_PRE) begin
      dt        <= started ? (smp.time_ms - last_upd) : 32'd0;
      dsq       <= 64'd0;
      still_all <= 1'b1;
    end
    if (state == S_MSCL && mul_done) a_r <= sprod[39:8];
    if (state == S_MGOLD && mul_done) t1 <= sprod[49:0];
    if (state == S_MGNEW && mul_done) gn_r <= gn;
    if (state == S_ACC) begin
      accv      <= accd;
      still_all <= still_all && (idt_pkg::mag32(accd) < {12'd0, noise_th});
    end
    if ((state == S_MVEL || state == S_MPOS) && mul_done) begin
      pmag <= mul_prod;
      psgn <= mul_sign;
    end
    if (state == S_MSQ && mul_done) dsq <= dsq + mul_prod;
    if (state == S_FIN && fin_go) begin
      result.position_x    <= pos[0];
      result.position_y    <= pos[1];
      result.position_z    <= pos[2];
      result.velocity_x    <= zero_vel ? 32'sd0 : vel[0];
      result.velocity_y    <= zero_vel ? 32'sd0 : vel[1];
      result.velocity_z    <= zero_vel ? 32'sd0 : vel[2];
      result.trigger       <= pulse_r;
      result.trigger_count <= pulses;
      result.warmed_up     <= warm;
    end
  end

endmodule

// ===== hw/rtl/idt_mul.sv =====
module idt_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [31:0] mcand;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] sum;

  // one multiplier bit per cycle
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : 33'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= 32'd0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[32:1];
      lo <= {sum[0], lo[31:1]};
    end
  end

endmodule

// ===== hw/rtl/idt_div.sv =====
module idt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] q;
  logic [9:0]  rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [10:0] trial;
  logic [10:0] diff;
  logic        ge;

  // restoring division by the constant, one quotient bit per cycle
  assign trial    = {rem, q[63]};
  assign ge       = trial >= {1'b0, idt_pkg::DIV_K};
  assign diff     = trial - {1'b0, idt_pkg::DIV_K};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= 10'd0;
    end else if (busy) begin
      rem <= ge ? diff[9:0] : trial[9:0];
      q   <= {q[62:0], ge};
    end
  end

endmodule

// ===== hw/rtl/idt_checker.sv =====
`include "inertial_displacement_tracker_unit_assert.svh"

module idt_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input idt_pkg::result_t result
);

  `IDT_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)
  `IDT_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result))
  `IDT_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)
  `IDT_ASSERT_IMP(a_trig_warm, result_valid && result.trigger, result.warmed_up)
  `IDT_ASSERT_IMP(a_trig_count, result_valid && result.trigger, result.trigger_count != 4'd0)

endmodule

bind inertial_displacement_tracker_unit idt_checker u_idt_checker (.*);
